@@ rtl/v3au_pkg.sv @@
`default_nettype none
package v3au_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  typedef enum logic [2:0] {
    OP_NEGATE    = 3'd0,
    OP_ADD       = 3'd1,
    OP_SUB       = 3'd2,
    OP_SCALE     = 3'd3,
    OP_EQUAL     = 3'd4,
    OP_LENGTH    = 3'd5,
    OP_NORMALIZE = 3'd6,
    OP_NOP       = 3'd7
  } op_t;

endpackage
`default_nettype wire

@@ rtl/v3au_lane.sv @@
`default_nettype none
module v3au_lane #(
  parameter int W = v3au_pkg::WORD_BITS,
  parameter int F = v3au_pkg::FRAC_BITS
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire v3au_pkg::op_t       op,
  input  wire logic signed [W-1:0] a,
  input  wire logic signed [W-1:0] b,
  input  wire logic signed [W-1:0] s,
  output logic signed [W-1:0]      res,
  output logic [2*W-1:0]           sq,
  output logic [W-1:0]             amag,
  output logic                     aneg
);

  logic [W-1:0]        a_abs;
  logic [W-1:0]        s_abs;
  logic signed [W:0]   sum;
  logic [W-1:0]        simple;

  v3au_pkg::op_t       op1;
  logic [W-1:0]        simple1;
  logic [2*W-1:0]      prod1;
  logic [2*W-1:0]      sqr1;
  logic [W-1:0]        amag1;
  logic                aneg1;
  logic                pneg1;

  logic [2*W-1:0]      sh;
  logic [2*W-1:0]      lim;
  logic [2*W-1:0]      sat;
  logic [W-1:0]        scaled;

  assign a_abs = a[W-1] ? (~a + 1'b1) : a;
  assign s_abs = s[W-1] ? (~s + 1'b1) : s;

  always_comb begin
    unique case (op)
      v3au_pkg::OP_NEGATE: sum = -{a[W-1], a};
      v3au_pkg::OP_ADD:    sum = {a[W-1], a} + {b[W-1], b};
      v3au_pkg::OP_SUB:    sum = {a[W-1], a} - {b[W-1], b};
      default:             sum = '0;
    endcase
    if (sum[W] != sum[W-1]) begin
      simple = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      simple = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1     <= op;
      simple1 <= simple;
      prod1   <= a_abs * s_abs;
      sqr1    <= a_abs * a_abs;
      amag1   <= a_abs;
      aneg1   <= a[W-1];
      pneg1   <= a[W-1] ^ s[W-1];
    end
  end

  always_comb begin
    sh     = prod1 >> F;
    lim    = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}} - {{(2*W-1){1'b0}}, ~pneg1};
    sat    = (sh > lim) ? lim : sh;
    scaled = pneg1 ? (~sat[W-1:0] + 1'b1) : sat[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res  <= (op1 == v3au_pkg::OP_SCALE) ? scaled : simple1;
      sq   <= sqr1;
      amag <= amag1;
      aneg <= aneg1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/v3au_sqrt.sv @@
`default_nettype none
module v3au_sqrt #(
  parameter int W = v3au_pkg::WORD_BITS
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [2*W-1:0] rad,
  output logic [W-1:0]        root
);

  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] rad_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W+1:0]   rem_p;
    logic [W-1:0]   root_p;
    logic [2*W-1:0] rad_p;
    logic [W+3:0]   r4;
    logic [W+3:0]   trial;
    logic [W+3:0]   diff;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
    end

    always_comb begin
      r4    = {rem_p, rad_p[2*W-1:2*W-2]};
      trial = {2'b00, root_p, 2'b01};
      diff  = r4 - trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (r4 >= trial) begin
          rem_q[k]  <= diff[W+1:0];
          root_q[k] <= {root_p[W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= r4[W+1:0];
          root_q[k] <= {root_p[W-2:0], 1'b0};
        end
        rad_q[k] <= rad_p << 2;
      end
    end
  end

  assign root = root_q[W-1];

endmodule
`default_nettype wire

@@ rtl/v3au_div.sv @@
`default_nettype none
module v3au_div #(
  parameter int W = v3au_pkg::WORD_BITS,
  parameter int F = v3au_pkg::FRAC_BITS
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] m,
  input  wire logic [W-1:0] d,
  output logic [F:0]        q
);

  // The quotient of (m << F) / d never exceeds 2^F when d >= m, so only the
  // low F+1 quotient bits are developed; the upper remainder starts at m >> 1.
  logic [W-1:0] rem_q [F+1];
  logic [W-1:0] d_q   [F+1];
  logic [F:0]   q_q   [F+1];

  for (genvar j = 0; j <= F; j++) begin : g_stage
    logic [W-1:0] rem_p;
    logic [W-1:0] d_p;
    logic [F:0]   q_p;
    logic         nbit;
    logic [W:0]   r2;
    logic [W:0]   diff;

    if (j == 0) begin : g_first
      assign rem_p = {1'b0, m[W-1:1]};
      assign d_p   = d;
      assign q_p   = '0;
      assign nbit  = m[0];
    end else begin : g_next
      assign rem_p = rem_q[j-1];
      assign d_p   = d_q[j-1];
      assign q_p   = q_q[j-1];
      assign nbit  = 1'b0;
    end

    always_comb begin
      r2   = {rem_p, nbit};
      diff = r2 - {1'b0, d_p};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (r2 >= {1'b0, d_p}) begin
          rem_q[j] <= diff[W-1:0];
          q_q[j]   <= {q_p[F-1:0], 1'b1};
        end else begin
          rem_q[j] <= r2[W-1:0];
          q_q[j]   <= {q_p[F-1:0], 1'b0};
        end
        d_q[j] <= d_p;
      end
    end
  end

  assign q = q_q[F];

endmodule
`default_nettype wire

@@ rtl/vector3_arithmetic_unit.sv @@
// Three-component vector ALU in signed fixed point (Q16.16 by default). It
// takes one word per cycle and returns one result word per input word, in
// order. Most of the pipeline is the digit-by-digit square root, one result
// bit per stage, followed by the restoring divider of normalize, one quotient
// bit per stage. Three lanes handle x, y and z side by side; the output
// register merges lane results according to the opcode. A stall at the
// output freezes the whole pipeline.
`default_nettype none
module vector3_arithmetic_unit #(
  parameter int FRAC_BITS = v3au_pkg::FRAC_BITS,
  parameter int WORD_BITS = v3au_pkg::WORD_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  opcode,
  input  wire logic signed [WORD_BITS-1:0] a_x,
  input  wire logic signed [WORD_BITS-1:0] a_y,
  input  wire logic signed [WORD_BITS-1:0] a_z,
  input  wire logic signed [WORD_BITS-1:0] b_x,
  input  wire logic signed [WORD_BITS-1:0] b_y,
  input  wire logic signed [WORD_BITS-1:0] b_z,
  input  wire logic signed [WORD_BITS-1:0] scale_factor,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [WORD_BITS-1:0]      r_x,
  output logic signed [WORD_BITS-1:0]      r_y,
  output logic signed [WORD_BITS-1:0]      r_z,
  output logic                             is_equal,
  output logic [WORD_BITS-1:0]             length,
  output logic                             zero_vector
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int SD = W + F + 1;
  localparam int P  = W + F + 3;
  localparam int QW = ((W > F + 1) ? W : F + 1) + 1;

  logic en;
  logic [P-1:0] vld;

  v3au_pkg::op_t op_in;
  v3au_pkg::op_t op1, op2;
  logic          eq1, eq2;

  logic signed [W-1:0] res   [3];
  logic [2*W-1:0]      sq    [3];
  logic [W-1:0]        amag  [3];
  logic                aneg  [3];

  logic [2*W-1:0] rad;
  logic [W-1:0]   root;

  v3au_pkg::op_t  side_op  [SD];
  logic           side_eq  [SD];
  logic [3*W-1:0] side_res [SD];
  logic [2:0]     side_neg [SD];
  logic [3*W-1:0] mag_dl   [W];
  logic [W-1:0]   len_dl   [F+1];
  logic [F:0]     quo      [3];

  v3au_pkg::op_t  op_f;
  logic [3*W-1:0] vec_f;
  logic [W-1:0]   rx_n, ry_n, rz_n, len_n;
  logic           eq_n, zero_n;

  function automatic logic [W-1:0] sat_q(input logic [F:0] qv, input logic neg);
    logic [QW-1:0] qe;
    logic [QW-1:0] lim;
    logic [QW-1:0] v;
    logic [QW-1:0] t;
    qe  = QW'(qv);
    lim = (QW'(1) << (W - 1)) - QW'({~neg});
    v   = (qe > lim) ? lim : qe;
    t   = neg ? (QW'(0) - v) : v;
    return t[W-1:0];
  endfunction

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign op_in    = v3au_pkg::op_t'(opcode);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[P-2:0], in_valid};
      out_valid <= vld[P-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= op_in;
      eq1 <= (a_x == b_x) && (a_y == b_y) && (a_z == b_z);
      op2 <= op1;
      eq2 <= eq1;
    end
  end

  v3au_lane #(.W(W), .F(F)) u_lane_x (
    .clk(clk), .en(en), .op(op_in), .a(a_x), .b(b_x), .s(scale_factor),
    .res(res[0]), .sq(sq[0]), .amag(amag[0]), .aneg(aneg[0])
  );
  v3au_lane #(.W(W), .F(F)) u_lane_y (
    .clk(clk), .en(en), .op(op_in), .a(a_y), .b(b_y), .s(scale_factor),
    .res(res[1]), .sq(sq[1]), .amag(amag[1]), .aneg(aneg[1])
  );
  v3au_lane #(.W(W), .F(F)) u_lane_z (
    .clk(clk), .en(en), .op(op_in), .a(a_z), .b(b_z), .s(scale_factor),
    .res(res[2]), .sq(sq[2]), .amag(amag[2]), .aneg(aneg[2])
  );

  // The sum of three squares of magnitudes up to 2^(W-1) stays below 2^(2W).
  assign rad = sq[0] + sq[1] + sq[2];

  v3au_sqrt #(.W(W)) u_sqrt (
    .clk(clk), .en(en), .rad(rad), .root(root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_op[0]  <= op2;
      side_eq[0]  <= eq2;
      side_res[0] <= {res[2], res[1], res[0]};
      side_neg[0] <= {aneg[2], aneg[1], aneg[0]};
      mag_dl[0]   <= {amag[2], amag[1], amag[0]};
      len_dl[0]   <= root;
      for (int k = 1; k < SD; k++) begin
        side_op[k]  <= side_op[k-1];
        side_eq[k]  <= side_eq[k-1];
        side_res[k] <= side_res[k-1];
        side_neg[k] <= side_neg[k-1];
      end
      for (int k = 1; k < W; k++) begin
        mag_dl[k] <= mag_dl[k-1];
      end
      for (int k = 1; k <= F; k++) begin
        len_dl[k] <= len_dl[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3au_div #(.W(W), .F(F)) u_div (
      .clk(clk), .en(en), .m(mag_dl[W-1][i*W +: W]), .d(root), .q(quo[i])
    );
  end

  always_comb begin
    op_f   = side_op[SD-1];
    vec_f  = side_res[SD-1];
    rx_n   = '0;
    ry_n   = '0;
    rz_n   = '0;
    len_n  = '0;
    eq_n   = 1'b0;
    zero_n = 1'b0;
    unique case (op_f)
      v3au_pkg::OP_NEGATE, v3au_pkg::OP_ADD, v3au_pkg::OP_SUB,
      v3au_pkg::OP_SCALE: begin
        rx_n = vec_f[W-1:0];
        ry_n = vec_f[2*W-1:W];
        rz_n = vec_f[3*W-1:2*W];
      end
      v3au_pkg::OP_EQUAL: begin
        eq_n = side_eq[SD-1];
      end
      v3au_pkg::OP_LENGTH: begin
        len_n = len_dl[F];
      end
      v3au_pkg::OP_NORMALIZE: begin
        if (len_dl[F] == '0) begin
          zero_n = 1'b1;
        end else begin
          rx_n = sat_q(quo[0], side_neg[SD-1][0]);
          ry_n = sat_q(quo[1], side_neg[SD-1][1]);
          rz_n = sat_q(quo[2], side_neg[SD-1][2]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_x         <= rx_n;
      r_y         <= ry_n;
      r_z         <= rz_n;
      length      <= len_n;
      is_equal    <= eq_n;
      zero_vector <= zero_n;
    end
  end

  a_zero_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_vector |-> r_x == '0 && r_y == '0 && r_z == '0 && length == '0)
    else $error("zero vector flag with nonzero result");

  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_equal |-> r_x == '0 && length == '0 && !zero_vector)
    else $error("equal flag with other fields set");

  a_len_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && length != '0 |-> !is_equal && !zero_vector && r_x == '0 && r_z == '0)
    else $error("length with other fields set");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !vld[P-1] |=> !out_valid)
    else $error("output word appeared without a word in the last stage");

endmodule
`default_nettype wire
